[rtl/source_token_lexer_macros.svh]
// Assertion helpers for the lexer. Each expects clk and rst_n in scope.
`ifndef SOURCE_TOKEN_LEXER_MACROS_SVH
`define SOURCE_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication.
`define STL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/stl_pkg.sv]
`timescale 1ns / 1ps
package stl_pkg;

  localparam int KIND_BITS    = 4;
  localparam int ERR_BITS     = 2;
  localparam int OFF_BITS     = 32;
  localparam int LEN_BITS     = 16;
  localparam int TAB_BITS     = 5;
  localparam int MAX_RES      = 3;
  localparam int RES_CNT_BITS = 2;
  localparam int FIFO_DEPTH   = 8;

  localparam logic [TAB_BITS-1:0] TAB_RESET = 5'd4;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_IDENT     = 4'd0,
    KIND_SEMI      = 4'd1,
    KIND_LBRACE    = 4'd2,
    KIND_RBRACE    = 4'd3,
    KIND_LPAREN    = 4'd4,
    KIND_RPAREN    = 4'd5,
    KIND_STRING    = 4'd6,
    KIND_DIRECTIVE = 4'd7,
    KIND_END       = 4'd8,
    KIND_ERROR     = 4'd9
  } kind_t;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_NONE        = 2'd0,
    ERR_UNTERM_STR  = 2'd1,
    ERR_HASH_COLUMN = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_DIRECTIVE = 2'd1,
    MODE_STRING    = 2'd2,
    MODE_COMMENT   = 2'd3
  } mode_t;

  // Byte presented to the lexer core and whether it is processed this cycle.
  typedef struct packed {
    logic       fire;
    logic [7:0] char_byte;
    logic       end_of_text;
  } step_t;

  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] len);
    len_inc = (len == '1) ? len : len + LEN_BITS'(1);
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    unique case (c)
      CH_SEMI:   punct_kind = KIND_SEMI;
      CH_LBRACE: punct_kind = KIND_LBRACE;
      CH_RBRACE: punct_kind = KIND_RBRACE;
      CH_LPAREN: punct_kind = KIND_LPAREN;
      CH_RPAREN: punct_kind = KIND_RPAREN;
      default:   punct_kind = KIND_IDENT;
    endcase
  endfunction

endpackage

[rtl/stl_in_if.sv]
`timescale 1ns / 1ps
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

[rtl/stl_out_if.sv]
`timescale 1ns / 1ps
interface stl_out_if
  import stl_pkg::*;
#(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [KIND_BITS-1:0]   token_kind;
  logic [ERR_BITS-1:0]    error_code;
  logic [LINE_BITS-1:0]   line_number;
  logic [COLUMN_BITS-1:0] column_number;
  logic [OFF_BITS-1:0]    start_offset;
  logic [LEN_BITS-1:0]    token_length;
  logic                   last_of_run;

  modport source (
    output valid, output token_kind, output error_code, output line_number,
    output column_number, output start_offset, output token_length,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input error_code, input line_number,
    input column_number, input start_offset, input token_length,
    input last_of_run, output ready
  );
endinterface

[rtl/stl_result_fifo.sv]
`timescale 1ns / 1ps
`include "source_token_lexer_macros.svh"
// Register FIFO taking up to MAX_RES entries per cycle, one out per cycle.
// DEPTH must be a power of two.
module stl_result_fifo
  import stl_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [RES_CNT_BITS-1:0] wr_count,
  input  logic [WIDTH-1:0]        wr_data [MAX_RES],
  output logic                    room,
  output logic                    rd_valid,
  input  logic                    rd_ready,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic [AW-1:0]    waddr [MAX_RES];
  logic             pop;

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rptr_r];
  assign pop      = rd_valid && rd_ready;
  // Room for a worst-case burst, judged on the registered count only.
  assign room     = (count_r <= (AW+1)'(DEPTH - MAX_RES));

  always_comb begin
    for (int j = 0; j < MAX_RES; j++) begin
      waddr[j] = wptr_r + AW'(j);
    end
    wptr_nxt  = wptr_r + AW'(wr_count);
    rptr_nxt  = pop ? rptr_r + AW'(1) : rptr_r;
    count_nxt = count_r + (AW+1)'(wr_count) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (RES_CNT_BITS'(j) < wr_count) begin
        mem[waddr[j]] <= wr_data[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  `STL_ASSERT_IMP(a_write_needs_room, wr_count != '0, room, "result FIFO written without room")
  `STL_ASSERT_IMP(a_count_bound, 1'b1, count_r <= (AW+1)'(DEPTH), "result FIFO count overflow")

endmodule

[rtl/stl_core.sv]
`timescale 1ns / 1ps
`include "source_token_lexer_macros.svh"
// Lexer state and the per-byte decision logic. Up to three descriptors leave
// per processed byte, packed from slot 0 upwards.
module stl_core
  import stl_pkg::*;
#(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16,
  localparam int RES_W = KIND_BITS + ERR_BITS + LINE_BITS + COLUMN_BITS
                       + OFF_BITS + LEN_BITS + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  step_t                   step,
  input  logic                    cfg_we,
  input  logic [TAB_BITS-1:0]     cfg_wdata,
  output logic [RES_CNT_BITS-1:0] res_count,
  output logic [RES_W-1:0]        res_data [MAX_RES]
);

  typedef struct packed {
    kind_t                  kind;
    err_t                   err;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [OFF_BITS-1:0]    off;
    logic [LEN_BITS-1:0]    len;
    logic                   last;
  } res_t;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  logic [TAB_BITS-1:0]    tab_r;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [OFF_BITS-1:0]    off_r, off_nxt;
  logic [LINE_BITS-1:0]   tok_line_r, tok_line_nxt;
  logic [COLUMN_BITS-1:0] tok_col_r, tok_col_nxt;
  logic [OFF_BITS-1:0]    tok_off_r, tok_off_nxt;
  logic [LEN_BITS-1:0]    tok_len_r, tok_len_nxt;
  mode_t                  mode_r, mode_nxt;
  logic                   slash_r, slash_nxt;
  logic                   end_step;
  logic                   text_cleared;

  function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] c);
    col_inc = (c == '1) ? c : c + COLUMN_BITS'(1);
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] l);
    line_inc = (l == '1) ? l : l + LINE_BITS'(1);
  endfunction

  function automatic res_t mk(input kind_t k, input err_t e, input logic [LINE_BITS-1:0] l,
                              input logic [COLUMN_BITS-1:0] c,
                              input logic [OFF_BITS-1:0] o,
                              input logic [LEN_BITS-1:0] n);
    mk = '{kind: k, err: e, line: l, col: c, off: o, len: n, last: 1'b0};
  endfunction

  always_comb begin
    logic [7:0]             c;
    logic                   eot;
    logic                   consumed;
    logic                   slash_here;
    logic [LINE_BITS-1:0]   lpos;
    logic [COLUMN_BITS-1:0] cpos;
    logic [OFF_BITS-1:0]    opos;
    logic [COLUMN_BITS:0]   tab_sum;
    res_t                   cand [4];
    logic [3:0]             cv;
    res_t                   slots [4];
    logic [2:0]             k;

    c          = step.char_byte;
    eot        = step.end_of_text;
    consumed   = 1'b0;
    slash_here = 1'b0;
    lpos       = line_r;
    cpos       = col_inc(col_r);
    opos       = off_r;
    cv         = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i]  = '0;
      slots[i] = '0;
    end

    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    tok_off_nxt  = tok_off_r;
    tok_len_nxt  = tok_len_r;
    mode_nxt     = mode_r;
    slash_nxt    = 1'b0;

    // Resolve a held slash: comment opener or part of an identifier.
    if (slash_r) begin
      if (c == CH_SLASH) begin
        if (tok_len_nxt != '0) begin
          cv[0]   = 1'b1;
          cand[0] = mk(KIND_IDENT, ERR_NONE, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                       tok_len_nxt);
          tok_len_nxt = '0;
        end
        mode_nxt = MODE_COMMENT;
        consumed = 1'b1;
      end else if (tok_len_nxt == '0) begin
        tok_line_nxt = line_r;
        tok_col_nxt  = col_r;
        tok_off_nxt  = off_r - OFF_BITS'(1);
        tok_len_nxt  = LEN_BITS'(1);
      end else begin
        tok_len_nxt = len_inc(tok_len_nxt);
      end
    end

    if (!consumed) begin
      unique case (mode_r)
        MODE_NORMAL: begin
          unique case (c)
            CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN: begin
              if (tok_len_nxt != '0) begin
                cv[0]   = 1'b1;
                cand[0] = mk(KIND_IDENT, ERR_NONE, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                             tok_len_nxt);
                tok_len_nxt = '0;
              end
              cv[1]   = 1'b1;
              cand[1] = mk(punct_kind(c), ERR_NONE, lpos, cpos, opos, LEN_BITS'(1));
            end
            CH_LF, CH_SPACE, CH_TAB: begin
              if (tok_len_nxt != '0) begin
                cv[0]   = 1'b1;
                cand[0] = mk(KIND_IDENT, ERR_NONE, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                             tok_len_nxt);
                tok_len_nxt = '0;
              end
            end
            CH_QUOTE: begin
              if (tok_len_nxt != '0) begin
                cv[0]   = 1'b1;
                cand[0] = mk(KIND_IDENT, ERR_NONE, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                             tok_len_nxt);
              end
              tok_line_nxt = lpos;
              tok_col_nxt  = cpos;
              tok_off_nxt  = opos;
              tok_len_nxt  = LEN_BITS'(1);
              mode_nxt     = MODE_STRING;
            end
            CH_HASH: begin
              if (tok_len_nxt != '0) begin
                cv[0]   = 1'b1;
                cand[0] = mk(KIND_IDENT, ERR_NONE, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                             tok_len_nxt);
                tok_len_nxt = '0;
              end
              if (col_r == '0) begin
                tok_line_nxt = lpos;
                tok_col_nxt  = cpos;
                tok_off_nxt  = opos;
                tok_len_nxt  = LEN_BITS'(1);
                mode_nxt     = MODE_DIRECTIVE;
              end else begin
                cv[1]   = 1'b1;
                cand[1] = mk(KIND_ERROR, ERR_HASH_COLUMN, lpos, cpos, opos, LEN_BITS'(1));
              end
            end
            CH_SLASH: begin
              // Hold the slash for one byte, unless the text ends here.
              if (eot) begin
                slash_here = 1'b1;
              end else begin
                slash_nxt = 1'b1;
              end
            end
            default: begin
              if (tok_len_nxt == '0) begin
                tok_line_nxt = lpos;
                tok_col_nxt  = cpos;
                tok_off_nxt  = opos;
                tok_len_nxt  = LEN_BITS'(1);
              end else begin
                tok_len_nxt = len_inc(tok_len_nxt);
              end
            end
          endcase
        end
        MODE_DIRECTIVE: begin
          if (c == CH_LF) begin
            cv[1]   = 1'b1;
            cand[1] = mk(KIND_DIRECTIVE, ERR_NONE, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                         tok_len_nxt);
            tok_len_nxt = '0;
            mode_nxt    = MODE_NORMAL;
          end else begin
            tok_len_nxt = len_inc(tok_len_nxt);
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            cv[1]   = 1'b1;
            cand[1] = mk(KIND_STRING, ERR_NONE, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                         len_inc(tok_len_nxt));
            tok_len_nxt = '0;
            mode_nxt    = MODE_NORMAL;
          end else if (c == CH_LF) begin
            cv[1]   = 1'b1;
            cand[1] = mk(KIND_ERROR, ERR_UNTERM_STR, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                         tok_len_nxt);
            tok_len_nxt = '0;
            mode_nxt    = MODE_NORMAL;
          end else begin
            tok_len_nxt = len_inc(tok_len_nxt);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_LF) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
        end
      endcase
    end

    // Position counters follow the raw byte in every mode.
    tab_sum = {1'b0, col_r} + (COLUMN_BITS+1)'(tab_r);
    off_nxt = off_r + OFF_BITS'(1);
    if (c == CH_LF) begin
      line_nxt = line_inc(line_r);
      col_nxt  = '0;
    end else if (c == CH_TAB) begin
      line_nxt = line_r;
      col_nxt  = tab_sum[COLUMN_BITS] ? '1 : tab_sum[COLUMN_BITS-1:0];
    end else begin
      line_nxt = line_r;
      col_nxt  = col_inc(col_r);
    end

    if (eot) begin
      if (slash_here) begin
        if (tok_len_nxt == '0) begin
          tok_line_nxt = lpos;
          tok_col_nxt  = cpos;
          tok_off_nxt  = opos;
          tok_len_nxt  = LEN_BITS'(1);
        end else begin
          tok_len_nxt = len_inc(tok_len_nxt);
        end
      end
      unique case (mode_nxt)
        MODE_NORMAL: begin
          cv[2]   = (tok_len_nxt != '0);
          cand[2] = mk(KIND_IDENT, ERR_NONE, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                       tok_len_nxt);
        end
        MODE_DIRECTIVE: begin
          cv[2]   = 1'b1;
          cand[2] = mk(KIND_DIRECTIVE, ERR_NONE, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                       tok_len_nxt);
        end
        MODE_STRING: begin
          cv[2]   = 1'b1;
          cand[2] = mk(KIND_ERROR, ERR_UNTERM_STR, tok_line_nxt, tok_col_nxt, tok_off_nxt,
                       tok_len_nxt);
        end
        default: begin
          cv[2] = 1'b0;
        end
      endcase
      cv[3]   = 1'b1;
      cand[3] = mk(KIND_END, ERR_NONE, line_nxt, col_inc(col_nxt), off_nxt, '0);
      // Start a fresh text; the tab width survives.
      line_nxt     = LINE_ONE;
      col_nxt      = '0;
      off_nxt      = '0;
      tok_line_nxt = LINE_ONE;
      tok_col_nxt  = '0;
      tok_off_nxt  = '0;
      tok_len_nxt  = '0;
      mode_nxt     = MODE_NORMAL;
      slash_nxt    = 1'b0;
    end

    // Pack the candidates in emission order.
    k = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && step.fire) begin
        slots[k[1:0]] = cand[i];
        k = k + 3'd1;
      end
    end
    if (k != '0) begin
      slots[k[1:0] - 2'd1].last = 1'b1;
    end
    res_count = k[RES_CNT_BITS-1:0];
    for (int i = 0; i < MAX_RES; i++) begin
      res_data[i] = slots[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_r      <= TAB_RESET;
      line_r     <= LINE_ONE;
      col_r      <= '0;
      off_r      <= '0;
      tok_line_r <= LINE_ONE;
      tok_col_r  <= '0;
      tok_off_r  <= '0;
      tok_len_r  <= '0;
      mode_r     <= MODE_NORMAL;
      slash_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        tab_r <= cfg_wdata;
      end
      if (step.fire) begin
        line_r     <= line_nxt;
        col_r      <= col_nxt;
        off_r      <= off_nxt;
        tok_line_r <= tok_line_nxt;
        tok_col_r  <= tok_col_nxt;
        tok_off_r  <= tok_off_nxt;
        tok_len_r  <= tok_len_nxt;
        mode_r     <= mode_nxt;
        slash_r    <= slash_nxt;
      end
    end
  end

  assign end_step     = step.fire && step.end_of_text;
  assign text_cleared = (mode_r == MODE_NORMAL) && (tok_len_r == '0) && !slash_r
                        && (off_r == '0);

  `STL_ASSERT_IMP(a_no_result_when_idle, !step.fire, res_count == '0, "result without a byte")
  `STL_ASSERT_NXT(a_end_clears_state, end_step, text_cleared, "state not cleared at text end")

endmodule

[rtl/source_token_lexer.sv]
`timescale 1ns / 1ps
// Byte-stream lexer. in_ch carries one source byte per transaction plus an
// end_of_text flag on the final byte; out_ch carries token descriptors
// (kind, error code, line, column, offset, length, last_of_run). A byte
// gives zero to three descriptors; last_of_run marks the final one of a byte,
// and the byte that ends the text always closes with an end token.
// cfg_we/cfg_wdata write the tab width (reset 4); write only while idle.
// An accepted byte waits in the input register and is decoded when the
// result FIFO has room; its descriptors go into the FIFO, which drives out_ch.
// Throughput: one byte per cycle while the FIFO has room, bounded by the
// single-descriptor output port. The input register is decoded only while the
// eight-entry result FIFO has space for three descriptors; descriptors drain
// one at a time and in_ch.ready drops while a held byte finds no such space.
// A stalled receiver keeps its descriptor at the FIFO head and the input
// stalls in turn; nothing is lost or repeated.
// Reset (synchronous, active low) empties the FIFO and input register and
// returns line 1, column 0, offset 0 and tab width 4.
module source_token_lexer
  import stl_pkg::*;
#(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  stl_in_if.sink                in_ch,
  stl_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [TAB_BITS-1:0]   cfg_wdata
);

  localparam int RES_W = KIND_BITS + ERR_BITS + LINE_BITS + COLUMN_BITS
                       + OFF_BITS + LEN_BITS + 1;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [ERR_BITS-1:0]    err;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [OFF_BITS-1:0]    off;
    logic [LEN_BITS-1:0]    len;
    logic                   last;
  } res_t;

  logic                    stg_v_r, stg_v_nxt;
  logic [7:0]              stg_char_r;
  logic                    stg_eot_r;
  logic                    room;
  logic                    fire;
  logic                    accept;
  step_t                   step;
  logic [RES_CNT_BITS-1:0] res_count;
  logic [RES_W-1:0]        res_data [MAX_RES];
  logic [RES_W-1:0]        head_raw;
  res_t                    head;

  assign fire         = stg_v_r && room;
  assign in_ch.ready  = !stg_v_r || room;
  assign accept       = in_ch.valid && in_ch.ready;
  assign stg_v_nxt    = accept ? 1'b1 : (fire ? 1'b0 : stg_v_r);
  assign step         = '{fire: fire, char_byte: stg_char_r, end_of_text: stg_eot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  // Payload of the input register; hold while the FIFO has no room.
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_char_r <= in_ch.char_byte;
      stg_eot_r  <= in_ch.end_of_text;
    end
  end

  stl_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_count (res_count),
    .res_data  (res_data)
  );

  stl_result_fifo #(
    .WIDTH (RES_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_count (res_count),
    .wr_data  (res_data),
    .room     (room),
    .rd_valid (out_ch.valid),
    .rd_ready (out_ch.ready),
    .rd_data  (head_raw)
  );

  assign head                 = res_t'(head_raw);
  assign out_ch.token_kind    = head.kind;
  assign out_ch.error_code    = head.err;
  assign out_ch.line_number   = head.line;
  assign out_ch.column_number = head.col;
  assign out_ch.start_offset  = head.off;
  assign out_ch.token_length  = head.len;
  assign out_ch.last_of_run   = head.last;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench
  import stl_pkg::*;
;
  localparam int LINE_W       = 24;
  localparam int COL_W        = 16;
  localparam int HOLD_CYCLES  = 90;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int DRAIN_PAUSE  = 10;
  localparam int RUN_LIMIT_NS = 3_000_000;

  localparam logic [7:0] PUNCT [5] = '{CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN};
  localparam logic [7:0] BLANKS [3] = '{CH_SPACE, CH_TAB, CH_LF};

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } src_byte_t;

  typedef struct {
    kind_t              kind;
    err_t               err;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
    logic [OFF_BITS-1:0] off;
    logic [LEN_BITS-1:0] len;
    logic               last;
  } token_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we;
  logic [TAB_BITS-1:0] cfg_wdata;

  stl_in_if in_ch ();
  stl_out_if #(.LINE_BITS(LINE_W), .COLUMN_BITS(COL_W)) out_ch ();

  source_token_lexer #(.LINE_BITS(LINE_W), .COLUMN_BITS(COL_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  src_byte_t   pending_bytes[$];
  logic [7:0]  draft[$];
  token_t      due_tokens[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned accepted_bytes = 0;
  int unsigned checked_tokens = 0;
  int unsigned hold_at = 32'hFFFF_FFFF;
  int unsigned hold_left;
  logic        hold_done;
  int          fail_count = 0;

  // Lexer state as seen by the checker
  logic [TAB_BITS-1:0] tab_w;
  logic [LINE_W-1:0]   cur_line;
  logic [COL_W-1:0]    cur_col;
  logic [OFF_BITS-1:0] cur_off;
  logic [LINE_W-1:0]   tok_line;
  logic [COL_W-1:0]    tok_col;
  logic [OFF_BITS-1:0] tok_off;
  logic [LEN_BITS-1:0] tok_len;
  mode_t               lex_mode;
  logic                slash_pending;

  function automatic logic [COL_W-1:0] col_sat(input logic [COL_W-1:0] a,
                                               input logic [TAB_BITS-1:0] b);
    logic [COL_W:0] s;
    s = {1'b0, a} + (COL_W + 1)'(b);
    col_sat = s[COL_W] ? '1 : s[COL_W-1:0];
  endfunction

  function automatic logic [LEN_BITS-1:0] len_step(input logic [LEN_BITS-1:0] n);
    len_step = (n == '1) ? n : n + LEN_BITS'(1);
  endfunction

  function automatic void reset_text();
    cur_line      = LINE_W'(1);
    cur_col       = '0;
    cur_off       = '0;
    tok_line      = LINE_W'(1);
    tok_col       = '0;
    tok_off       = '0;
    tok_len       = '0;
    lex_mode      = MODE_NORMAL;
    slash_pending = 1'b0;
  endfunction

  function automatic void push_token(input kind_t k, input err_t e, input logic [LINE_W-1:0] l,
                                     input logic [COL_W-1:0] c, input logic [OFF_BITS-1:0] o,
                                     input logic [LEN_BITS-1:0] n);
    token_t t;
    t = '{kind: k, err: e, line: l, col: c, off: o, len: n, last: 1'b0};
    due_tokens.insert(due_tokens.size(), t);
  endfunction

  function automatic void start_token(input logic [LINE_W-1:0] l, input logic [COL_W-1:0] c,
                                      input logic [OFF_BITS-1:0] o);
    tok_line = l;
    tok_col  = c;
    tok_off  = o;
    tok_len  = LEN_BITS'(1);
  endfunction

  function automatic void grow_ident(input logic [LINE_W-1:0] l, input logic [COL_W-1:0] c,
                                     input logic [OFF_BITS-1:0] o);
    if (tok_len == 0) start_token(l, c, o);
    else tok_len = len_step(tok_len);
  endfunction

  function automatic void flush_tok(input kind_t k, input err_t e);
    push_token(k, e, tok_line, tok_col, tok_off, tok_len);
    tok_len = '0;
  endfunction

  function automatic void flush_ident();
    if (tok_len != 0) flush_tok(KIND_IDENT, ERR_NONE);
  endfunction

  // Work out the descriptors one accepted byte gives and queue them
  function automatic void lex_byte(input logic [7:0] ch, input logic eot);
    logic [LINE_W-1:0]   l0;
    logic [COL_W-1:0]    c0;
    logic [OFF_BITS-1:0] o0;
    logic                consumed;
    logic                slash_now;
    kind_t               pk;
    int                  first;
    first     = due_tokens.size();
    l0        = cur_line;
    c0        = col_sat(cur_col, TAB_BITS'(1));
    o0        = cur_off;
    consumed  = 1'b0;
    slash_now = 1'b0;

    if (slash_pending) begin
      slash_pending = 1'b0;
      if (ch == CH_SLASH) begin
        flush_ident();
        lex_mode = MODE_COMMENT;
        consumed = 1'b1;
      end else begin
        grow_ident(cur_line, cur_col, cur_off - OFF_BITS'(1));
      end
    end

    if (!consumed) begin
      case (lex_mode)
        MODE_NORMAL: begin
          case (ch)
            CH_SEMI:   pk = KIND_SEMI;
            CH_LBRACE: pk = KIND_LBRACE;
            CH_RBRACE: pk = KIND_RBRACE;
            CH_LPAREN: pk = KIND_LPAREN;
            CH_RPAREN: pk = KIND_RPAREN;
            default:   pk = KIND_IDENT;
          endcase
          if (pk != KIND_IDENT) begin
            flush_ident();
            push_token(pk, ERR_NONE, l0, c0, o0, LEN_BITS'(1));
          end else if (ch == CH_LF || ch == CH_SPACE || ch == CH_TAB) begin
            flush_ident();
          end else if (ch == CH_QUOTE) begin
            flush_ident();
            start_token(l0, c0, o0);
            lex_mode = MODE_STRING;
          end else if (ch == CH_HASH) begin
            flush_ident();
            if (cur_col == 0) begin
              start_token(l0, c0, o0);
              lex_mode = MODE_DIRECTIVE;
            end else begin
              push_token(KIND_ERROR, ERR_HASH_COLUMN, l0, c0, o0, LEN_BITS'(1));
            end
          end else if (ch == CH_SLASH) begin
            // hold the slash back until the next byte shows whether a comment opens
            if (eot) slash_now = 1'b1;
            else slash_pending = 1'b1;
          end else begin
            grow_ident(l0, c0, o0);
          end
        end
        MODE_DIRECTIVE: begin
          if (ch == CH_LF) begin
            flush_tok(KIND_DIRECTIVE, ERR_NONE);
            lex_mode = MODE_NORMAL;
          end else begin
            tok_len = len_step(tok_len);
          end
        end
        MODE_STRING: begin
          if (ch == CH_QUOTE) begin
            tok_len = len_step(tok_len);
            flush_tok(KIND_STRING, ERR_NONE);
            lex_mode = MODE_NORMAL;
          end else if (ch == CH_LF) begin
            flush_tok(KIND_ERROR, ERR_UNTERM_STR);
            lex_mode = MODE_NORMAL;
          end else begin
            tok_len = len_step(tok_len);
          end
        end
        default: begin
          if (ch == CH_LF) lex_mode = MODE_NORMAL;
        end
      endcase
    end

    if (ch == CH_LF) begin
      cur_line = (cur_line == '1) ? cur_line : cur_line + LINE_W'(1);
      cur_col  = '0;
    end else if (ch == CH_TAB) begin
      cur_col = col_sat(cur_col, tab_w);
    end else begin
      cur_col = col_sat(cur_col, TAB_BITS'(1));
    end
    cur_off = cur_off + OFF_BITS'(1);

    if (eot) begin
      if (slash_now) grow_ident(l0, c0, o0);
      case (lex_mode)
        MODE_NORMAL:    flush_ident();
        MODE_DIRECTIVE: flush_tok(KIND_DIRECTIVE, ERR_NONE);
        MODE_STRING:    flush_tok(KIND_ERROR, ERR_UNTERM_STR);
        default:        ;
      endcase
      push_token(KIND_END, ERR_NONE, cur_line, col_sat(cur_col, TAB_BITS'(1)), cur_off, '0);
      reset_text();
    end

    if (due_tokens.size() > first) due_tokens[due_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    draft.insert(draft.size(), b);
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // Move the drafted text to the send queue, flagging its final byte
  function automatic void close_text();
    src_byte_t sb;
    foreach (draft[i]) begin
      sb = '{ch: draft[i], eot: (i == draft.size() - 1)};
      pending_bytes.insert(pending_bytes.size(), sb);
    end
    draft.delete();
  endfunction

  function automatic logic [7:0] filler(input logic no_quote);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_LF || (no_quote && b == CH_QUOTE));
    return b;
  endfunction

  // Mostly well-formed source with random content, with some broken pieces and noise
  task automatic gen_phase(input int unsigned target);
    int unsigned made;
    int unsigned sel;
    int unsigned n;
    made = 0;
    while (made < target) begin
      repeat ($urandom_range(1, 14)) begin
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            if (i != 0 && $urandom_range(0, 4) == 0) add_byte(CH_SLASH);
            add_byte(8'(8'h61 + $urandom_range(0, 25)));
          end
        end else if (sel < 45) begin
          add_byte(PUNCT[$urandom_range(0, 4)]);
        end else if (sel < 60) begin
          add_byte(BLANKS[$urandom_range(0, 2)]);
        end else if (sel < 70) begin
          add_byte(CH_QUOTE);
          repeat ($urandom_range(0, 5)) add_byte(filler(1'b1));
          add_byte(CH_QUOTE);
        end else if (sel < 76) begin
          if (draft.size() != 0 && draft[$] != CH_LF) add_byte(CH_LF);
          add_byte(CH_HASH);
          repeat ($urandom_range(0, 5)) add_byte(filler(1'b0));
          add_byte(CH_LF);
        end else if (sel < 82) begin
          add_str("//");
          repeat ($urandom_range(0, 5)) add_byte(filler(1'b0));
          add_byte(CH_LF);
        end else if (sel < 86) begin
          // misplaced hash
          if (draft.size() == 0 || draft[$] == CH_LF) add_byte(CH_SPACE);
          add_byte(CH_HASH);
        end else if (sel < 90) begin
          add_byte(CH_QUOTE);
          repeat ($urandom_range(0, 4)) add_byte(filler(1'b1));
          add_byte(CH_LF);
        end else begin
          add_byte(8'($urandom_range(0, 255)));
        end
      end
      made += draft.size();
      close_text();
    end
  endtask

  task automatic set_tab_width(input logic [TAB_BITS-1:0] w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tab_w     = w;
  endtask

  // Wait for the stimulus to go in and every expected descriptor to come out
  task automatic drain();
    int k;
    while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    k = 0;
    while (due_tokens.size() != 0 && k < DRAIN_LIMIT) begin
      @(posedge clk);
      k++;
    end
    if (due_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", due_tokens.size());
      fail_count++;
      due_tokens.delete();
    end
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : drive_bytes
    src_byte_t nxt;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.char_byte   <= 8'h00;
      in_ch.end_of_text <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        lex_byte(in_ch.char_byte, in_ch.end_of_text);
        accepted_bytes <= accepted_bytes + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.char_byte   <= nxt.ch;
          in_ch.end_of_text <= nxt.eot;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : pace_receiver
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && accepted_bytes >= hold_at) begin
      // long back-pressure so the result FIFO fills and the input stalls
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_tokens.size() == 0) begin
        $error("unexpected token: kind %0d at offset %0d", out_ch.token_kind, out_ch.start_offset);
        fail_count++;
      end else begin
        want = due_tokens.pop_front();
        check_field("token_kind", 32'(want.kind), 32'(out_ch.token_kind));
        check_field("error_code", 32'(want.err), 32'(out_ch.error_code));
        check_field("line_number", 32'(want.line), 32'(out_ch.line_number));
        check_field("column_number", 32'(want.col), 32'(out_ch.column_number));
        check_field("start_offset", want.off, out_ch.start_offset);
        check_field("token_length", 32'(want.len), 32'(out_ch.token_length));
        check_field("last_of_run", 32'(want.last), 32'(out_ch.last_of_run));
        checked_tokens++;
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("** source_token_lexer: FAILED **");
    $finish;
  end

  initial begin
    tab_w = TAB_RESET;
    reset_text();
    in_ch.valid       = 1'b0;
    in_ch.char_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 80;
    // directive, tab, slash inside an identifier, all punctuation, string,
    // misplaced hash, string broken by a newline, comment running to the end
    add_str("#p\n\tq/x(){};\"s\" #\"u\n//");
    close_text();
    add_str("\"u");
    close_text();
    add_str("#d");
    close_text();
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(CH_SLASH);
    close_text();
    drain();

    set_tab_width(5'd0);
    gen_phase(100);
    drain();

    send_idle_pct = 80;
    recv_idle_pct = 18;
    set_tab_width(5'd31);
    // wide tabs, then a string left open at the end of the text
    add_byte(8'h61);
    repeat (6) add_byte(CH_TAB);
    add_str("b;\"q");
    close_text();
    gen_phase(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_tab_width(5'd1);
    hold_at <= accepted_bytes + 40;
    gen_phase(110);
    drain();

    $display("Lexed %0d bytes into %0d checked tokens over tab widths 4, 0, 31 and 1,",
             accepted_bytes, checked_tokens);
    $display("with uneven pacing on both sides and one long output stall.");
    if (fail_count == 0) begin
      $display("** source_token_lexer: PASSED **");
    end else begin
      $display("** source_token_lexer: FAILED **");
    end
    $finish;
  end

endmodule
